// ===== rtl/core/c2p_pkg.sv =====
`timescale 1ns / 1ps
// Package for the cartesian to polar core.
// Holds the CORDIC arctangent table and the fixed internal widths; no dependencies.
package c2p_pkg;

  localparam int TURN_W   = 32;
  localparam int CORE_W   = 64;
  localparam int ATAN_LEN = 32;

  // atan(2^-i) as a fraction of a full turn, 2^32 = one turn
  localparam logic [TURN_W-1:0] ATAN_TURN [0:ATAN_LEN-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

endpackage

// ===== rtl/core/cartesian_to_polar_core.sv =====
`timescale 1ns / 1ps
// Cartesian to polar core: CORDIC vectoring for the angle, digit-by-digit square root
// for the magnitude, both in one shared pipeline. Depends on c2p_pkg.
// One word per cycle unless out_tready stalls the pipeline.
// Stages 3 .. LAST-1 hold the CORDIC rotations and root digits, at most one of each.
// Stalls collapse bubbles stage by stage; back-pressure reaches in_tready combinationally.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
module cartesian_to_polar_core #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ANGLE_WIDTH  = 16,
  parameter int ITERATIONS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // x_coord, y_coord, zero padding
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // angle_turns, magnitude, zero padding
  output logic [((ANGLE_WIDTH+SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  // at_origin
  output logic [0:0] out_tuser
);
  import c2p_pkg::*;

  localparam int SW      = SAMPLE_WIDTH;
  localparam int AW      = ANGLE_WIDTH;
  localparam int NITER   = (ITERATIONS < ATAN_LEN) ? ITERATIONS : ATAN_LEN;
  localparam int DEPTH   = (NITER > SW) ? NITER : SW;
  localparam int LAST    = DEPTH + 3;
  localparam int GUARD   = 61 - SW;
  localparam int RW      = SW + 2;
  localparam int SH      = TURN_W - AW;
  localparam int OUT_DW  = ((AW + SW + 7) / 8) * 8;
  localparam logic [TURN_W-1:0] ANG_RND =
    (SH > 0) ? (TURN_W'(1) << ((SH > 0) ? SH - 1 : 0)) : '0;

  logic                     valid_r  [0:LAST];
  logic                     en       [0:LAST];
  logic signed [CORE_W-1:0] x_r      [0:LAST-1];
  logic signed [CORE_W-1:0] y_r      [0:LAST-1];
  logic [TURN_W-1:0]        z_r      [0:LAST-1];
  logic                     origin_r [0:LAST-1];
  logic [2*SW-1:0]          s_r      [2:LAST-1];
  logic [RW-1:0]            rem_r    [2:LAST-1];
  logic [SW-1:0]            root_r   [2:LAST-1];
  logic [SW-1:0]            ax_r;
  logic [SW-1:0]            ay_r;
  logic [2*SW-1:0]          sqx_r;
  logic [2*SW-1:0]          sqy_r;

  logic [AW-1:0]            angle_r;
  logic [SW-1:0]            mag_r;
  logic                     at_origin_r;

  // handshake chain: a stage loads when it is empty or its successor loads
  assign en[LAST] = !valid_r[LAST] || out_tready;
  genvar g;
  generate
    for (g = 0; g < LAST; g++) begin : g_en
      assign en[g] = !valid_r[g] || en[g+1];
    end
  endgenerate

  assign in_tready  = en[0];
  assign out_tvalid = valid_r[LAST];
  assign out_tdata  = OUT_DW'({mag_r, angle_r});
  assign out_tuser  = at_origin_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) valid_r[k] <= 1'b0;
    end else begin
      if (en[0]) valid_r[0] <= in_tvalid;
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // stage 0: operand capture, scaling, half-plane fold, absolute values
  logic [SW-1:0]            x_in, y_in;
  logic signed [CORE_W-1:0] x_sc, y_sc;
  logic [SW-1:0]            ax_nxt, ay_nxt;

  always_comb begin
    x_in   = in_tdata[SW-1:0];
    y_in   = in_tdata[2*SW-1:SW];
    x_sc   = {{(CORE_W-SW){x_in[SW-1]}}, x_in} <<< GUARD;
    y_sc   = {{(CORE_W-SW){y_in[SW-1]}}, y_in} <<< GUARD;
    ax_nxt = x_in[SW-1] ? (~x_in + SW'(1)) : x_in;
    ay_nxt = y_in[SW-1] ? (~y_in + SW'(1)) : y_in;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]      <= x_in[SW-1] ? -x_sc : x_sc;
      y_r[0]      <= x_in[SW-1] ? -y_sc : y_sc;
      z_r[0]      <= x_in[SW-1] ? HALF_TURN : '0;
      origin_r[0] <= (x_in == '0) && (y_in == '0);
      ax_r        <= ax_nxt;
      ay_r        <= ay_nxt;
    end
  end

  // stage 1: squares
  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_r[1]      <= x_r[0];
      y_r[1]      <= y_r[0];
      z_r[1]      <= z_r[0];
      origin_r[1] <= origin_r[0];
      sqx_r       <= {{SW{1'b0}}, ax_r} * {{SW{1'b0}}, ax_r};
      sqy_r       <= {{SW{1'b0}}, ay_r} * {{SW{1'b0}}, ay_r};
    end
  end

  // stage 2: sum of squares, root state cleared
  always_ff @(posedge clk) begin
    if (en[2]) begin
      x_r[2]      <= x_r[1];
      y_r[2]      <= y_r[1];
      z_r[2]      <= z_r[1];
      origin_r[2] <= origin_r[1];
      s_r[2]      <= sqx_r + sqy_r;
      rem_r[2]    <= '0;
      root_r[2]   <= '0;
    end
  end

  // stages 3 .. LAST-1: a CORDIC rotation while J < NITER and a root digit while J < SW
  generate
    for (g = 3; g < LAST; g++) begin : g_stage
      localparam int J = g - 3;

      always_ff @(posedge clk) begin
        if (en[g]) begin
          origin_r[g] <= origin_r[g-1];
          s_r[g]      <= s_r[g-1];
        end
      end

      if (J < NITER) begin : g_rot
        logic signed [CORE_W-1:0] dx, dy;
        assign dx = y_r[g-1] >>> J;
        assign dy = x_r[g-1] >>> J;
        always_ff @(posedge clk) begin
          if (en[g]) begin
            if (!y_r[g-1][CORE_W-1]) begin
              x_r[g] <= x_r[g-1] + dx;
              y_r[g] <= y_r[g-1] - dy;
              z_r[g] <= z_r[g-1] + ATAN_TURN[J];
            end else begin
              x_r[g] <= x_r[g-1] - dx;
              y_r[g] <= y_r[g-1] + dy;
              z_r[g] <= z_r[g-1] - ATAN_TURN[J];
            end
          end
        end
      end else begin : g_rot_pass
        always_ff @(posedge clk) begin
          if (en[g]) begin
            x_r[g] <= x_r[g-1];
            y_r[g] <= y_r[g-1];
            z_r[g] <= z_r[g-1];
          end
        end
      end

      if (J < SW) begin : g_root
        localparam int P = 2 * (SW - 1 - J);
        logic [RW-1:0] rem_sh, trial;
        assign rem_sh = {rem_r[g-1][RW-3:0], s_r[g-1][P+1:P]};
        assign trial  = {root_r[g-1], 2'b01};
        always_ff @(posedge clk) begin
          if (en[g]) begin
            if (rem_sh >= trial) begin
              rem_r[g]  <= rem_sh - trial;
              root_r[g] <= {root_r[g-1][SW-2:0], 1'b1};
            end else begin
              rem_r[g]  <= rem_sh;
              root_r[g] <= {root_r[g-1][SW-2:0], 1'b0};
            end
          end
        end
      end else begin : g_root_pass
        always_ff @(posedge clk) begin
          if (en[g]) begin
            rem_r[g]  <= rem_r[g-1];
            root_r[g] <= root_r[g-1];
          end
        end
      end
    end
  endgenerate

  // output stage: angle rounding, magnitude rounding, origin override
  logic [TURN_W-1:0] z_rnd;
  logic [SW-1:0]     mag_nxt;

  always_comb begin
    z_rnd   = z_r[LAST-1] + ANG_RND;
    mag_nxt = root_r[LAST-1] +
              SW'(rem_r[LAST-1] > {2'b00, root_r[LAST-1]});
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      angle_r     <= origin_r[LAST-1] ? '0 : z_rnd[TURN_W-1:SH];
      mag_r       <= origin_r[LAST-1] ? '0 : mag_nxt;
      at_origin_r <= origin_r[LAST-1];
    end
  end

endmodule

// ===== rtl/core/c2p_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the cartesian to polar core, bound to the top level.
// Depends only on the top level's ports and parameters.
module c2p_checker #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ANGLE_WIDTH  = 16
) (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((ANGLE_WIDTH+SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic [0:0] out_tuser
);

  localparam int AW = ANGLE_WIDTH;
  localparam int SW = SAMPLE_WIDTH;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed or dropped");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output register is empty");

  a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("origin word with non-zero angle or magnitude");

  a_mag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[AW+SW-1:AW] != '0)
    else $error("non-origin word with zero magnitude");

endmodule

bind cartesian_to_polar_core c2p_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH),
  .ANGLE_WIDTH (ANGLE_WIDTH)
) u_c2p_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
